### sv/nnue_squared_crelu_output_eval_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the NNUE output layer core
// Shared property shapes for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef NNUE_SQUARED_CRELU_OUTPUT_EVAL_CORE_ASSERT_SVH
`define NNUE_SQUARED_CRELU_OUTPUT_EVAL_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NSCO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NSCO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/nsco_pkg.sv
// ---------------------------------------------------------------------------
// NNUE output layer package
// Field widths, register reset values, the types shared by the modules and the clipped ReLU clamp.
// ---------------------------------------------------------------------------
package nsco_pkg;

  localparam int ClipW    = 15;
  localparam int QuantW   = 10;
  localparam int ScaleW   = 16;
  localparam int DataW    = 16;
  localparam int SumW     = 64;
  localparam int EvalW    = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int JobDepth = 4;

  // Largest divisor is clip times quant.
  localparam int DivisorW = ClipW + QuantW;

  localparam logic [ClipW-1:0]  ClipReset  = ClipW'(255);
  localparam logic [QuantW-1:0] QuantReset = QuantW'(64);
  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(400);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLIP  = 2'd0,
    CFG_QUANT = 2'd1,
    CFG_SCALE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ClipW-1:0]  clip;
    logic [QuantW-1:0] quant;
    logic [ScaleW-1:0] scale;
  } cfg_t;

  // One finished vector handed from the accumulator to the output stage.
  typedef struct packed {
    logic [SumW-1:0]         sum;
    logic signed [DataW-1:0] bias;
    logic                    white;
  } job_t;

  // Clipped ReLU: clamp a signed accumulator value into 0..clip.
  function automatic logic [ClipW-1:0] clamp_act(logic signed [DataW-1:0] a,
                                                 logic [ClipW-1:0] clip);
    logic [ClipW-1:0] mag;
    mag = a[ClipW-1:0];
    if (a[DataW-1]) begin
      return '0;
    end else if (mag > clip) begin
      return clip;
    end
    return mag;
  endfunction

endpackage

### sv/nsco_front.sv
// ---------------------------------------------------------------------------
// NNUE output layer front end
// Accepts one hidden unit per cycle while full is low, squares and weights
// both halves, accumulates the 64-bit sum; hands finished vectors on as jobs.
// ---------------------------------------------------------------------------
module nsco_front import nsco_pkg::*; #(
  parameter int JOB_DEPTH = JobDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cfg_t                            cfg_i,
  input  logic                            push,
  output logic                            full,
  input  logic signed [DataW-1:0]         acc_white_i,
  input  logic signed [DataW-1:0]         acc_black_i,
  input  logic signed [DataW-1:0]         weight_us_i,
  input  logic signed [DataW-1:0]         weight_them_i,
  input  logic signed [DataW-1:0]         output_bias_i,
  input  logic                            white_to_move_i,
  input  logic                            last_unit_i,
  input  logic [$clog2(JOB_DEPTH+1)-1:0]  job_free_i,
  output logic                            job_push_o,
  output job_t                            job_o
);

  localparam int CntW  = $clog2(JOB_DEPTH + 1);
  localparam int SqW   = 2 * ClipW;
  localparam int ProdW = SqW + 1 + DataW;

  logic accept;
  logic [CntW-1:0] pipe_lasts;

  // Control of the three stages ahead of the accumulator.
  logic v1_q, v2_q, v3_q;
  logic l1_q, l2_q, l3_q;

  // Payload of the stages.
  logic [ClipW-1:0]        us1_q, them1_q;
  logic signed [DataW-1:0] wu1_q, wt1_q, wu2_q, wt2_q;
  logic signed [DataW-1:0] bias1_q, bias2_q, bias3_q;
  logic                    white1_q, white2_q, white3_q;
  logic [SqW-1:0]          sq_us2_q, sq_them2_q;
  logic signed [ProdW-1:0] p_us3_q, p_them3_q;

  logic [SumW-1:0] sum_q, sum_d;

  // A last unit already in flight will claim a job slot; hold off until
  // every one of them is sure of its place.
  assign pipe_lasts = CntW'(v1_q & l1_q) + CntW'(v2_q & l2_q) + CntW'(v3_q & l3_q);
  assign full       = (pipe_lasts >= job_free_i);
  assign accept     = push & ~full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      l1_q <= 1'b0;
      l2_q <= 1'b0;
      l3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      l1_q <= accept & last_unit_i;
      l2_q <= l1_q;
      l3_q <= l2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // Stage 1: side selection and clamp.
    us1_q    <= clamp_act(white_to_move_i ? acc_white_i : acc_black_i, cfg_i.clip);
    them1_q  <= clamp_act(white_to_move_i ? acc_black_i : acc_white_i, cfg_i.clip);
    wu1_q    <= weight_us_i;
    wt1_q    <= weight_them_i;
    bias1_q  <= output_bias_i;
    white1_q <= white_to_move_i;
    // Stage 2: squares.
    sq_us2_q   <= SqW'(us1_q) * SqW'(us1_q);
    sq_them2_q <= SqW'(them1_q) * SqW'(them1_q);
    wu2_q      <= wu1_q;
    wt2_q      <= wt1_q;
    bias2_q    <= bias1_q;
    white2_q   <= white1_q;
    // Stage 3: weighting.
    p_us3_q   <= ProdW'($signed({1'b0, sq_us2_q})) * ProdW'(wu2_q);
    p_them3_q <= ProdW'($signed({1'b0, sq_them2_q})) * ProdW'(wt2_q);
    bias3_q   <= bias2_q;
    white3_q  <= white2_q;
  end

  assign sum_d = sum_q + SumW'(p_us3_q) + SumW'(p_them3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (v3_q) begin
      sum_q <= l3_q ? '0 : sum_d;
    end
  end

  assign job_push_o  = v3_q & l3_q;
  assign job_o.sum   = sum_d;
  assign job_o.bias  = bias3_q;
  assign job_o.white = white3_q;

endmodule

### sv/nsco_job_fifo.sv
// ---------------------------------------------------------------------------
// NNUE output layer job queue
// Short queue of finished vectors between the front end and the back end.
// ---------------------------------------------------------------------------
module nsco_job_fifo import nsco_pkg::*; #(
  parameter int DEPTH = JobDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  job_t                        job_i,
  input  logic                        pop_i,
  output logic                        valid_o,
  output job_t                        job_o,
  output logic [$clog2(DEPTH+1)-1:0]  free_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  // The front end never pushes into a full queue.
  assign do_push = push_i;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_q];
  assign free_o  = CntW'(DEPTH) - count_q;

endmodule

### sv/nsco_back.sv
// ---------------------------------------------------------------------------
// NNUE output layer back end
// Sequencer around one shared bit-serial divider: sum / clip, bias, the
// scaled division by clip * quant, sign and saturation; holds the result.
// ---------------------------------------------------------------------------
module nsco_back import nsco_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    job_valid_i,
  input  job_t                    job_i,
  output logic                    job_pop_o,
  output logic                    res_valid_o,
  input  logic                    res_pop_i,
  output logic signed [EvalW-1:0] evaluation_o
);

  localparam int CntW  = $clog2(SumW);
  localparam int PqW   = EvalW - 1 + ScaleW;
  localparam int TmW   = PqW + 1;
  localparam int RsW   = DivisorW + ScaleW;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIVA = 8'b0000_0010,
    ST_ADJ  = 8'b0000_0100,
    ST_LDB  = 8'b0000_1000,
    ST_DIVB = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_DIVC = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [SumW-1:0]         quo_q, quo_d;
  logic [DivisorW-1:0]     rem_q, rem_d;
  logic [DivisorW-1:0]     divisor_q, divisor_d;
  logic                    sign_q, sign_d;
  logic signed [DataW-1:0] bias_q, bias_d;
  logic                    white_q, white_d;
  logic [SumW-1:0]         v_q, v_d;
  logic                    big_q, big_d;
  logic [PqW-1:0]          pq_q, pq_d;
  logic signed [EvalW-1:0] res_q, res_d;
  logic                    res_valid_q, res_valid_d;

  logic [ClipW-1:0]         qa_eff;
  logic [QuantW-1:0]        oq_eff;
  logic [DivisorW:0]        trial, diff;
  logic                     ge;
  logic [DivisorW-1:0]      rem_step;
  logic signed [SumW:0]     s_wide, v_wide;
  logic [SumW-1:0]          v_sat;
  logic [RsW-1:0]           rs;
  logic [TmW-1:0]           tm;
  logic                     neg, sat;
  logic signed [EvalW-1:0]  eval;

  // Zero divisors act as one.
  assign qa_eff = (cfg_i.clip == '0) ? ClipW'(1) : cfg_i.clip;
  assign oq_eff = (cfg_i.quant == '0) ? QuantW'(1) : cfg_i.quant;

  // One restoring division step.
  assign trial    = {rem_q, quo_q[SumW-1]};
  assign ge       = (trial >= {1'b0, divisor_q});
  assign diff     = trial - {1'b0, divisor_q};
  assign rem_step = ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];

  // Signed quotient plus bias, saturated to 64 bits.
  assign s_wide = sign_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign v_wide = s_wide + (SumW+1)'(bias_q);
  always_comb begin
    if (v_wide[SumW] != v_wide[SumW-1]) begin
      v_sat = v_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      v_sat = v_wide[SumW-1:0];
    end
  end

  assign rs = RsW'(rem_q) * RsW'(cfg_i.scale);

  // Final magnitude: integer part times scale plus the scaled fraction.
  assign tm   = TmW'(pq_q) + TmW'(quo_q[ScaleW-1:0]);
  assign neg  = sign_q ^ ~white_q;
  assign sat  = (big_q && (cfg_i.scale != '0)) || (tm[TmW-1:EvalW-1] != '0);
  always_comb begin
    if (sat) begin
      eval = neg ? {1'b1, {(EvalW-1){1'b0}}} : {1'b0, {(EvalW-1){1'b1}}};
    end else begin
      eval = neg ? -$signed(tm[EvalW-1:0]) : $signed(tm[EvalW-1:0]);
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    divisor_d   = divisor_q;
    sign_d      = sign_q;
    bias_d      = bias_q;
    white_d     = white_q;
    v_d         = v_q;
    big_d       = big_q;
    pq_d        = pq_q;
    res_d       = res_q;
    res_valid_d = res_valid_q & ~res_pop_i;
    job_pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          quo_d     = job_i.sum[SumW-1] ? -job_i.sum : job_i.sum;
          rem_d     = '0;
          divisor_d = DivisorW'(qa_eff);
          sign_d    = job_i.sum[SumW-1];
          bias_d    = job_i.bias;
          white_d   = job_i.white;
          cnt_d     = CntW'(SumW - 1);
          state_d   = ST_DIVA;
        end
      end
      ST_DIVA, ST_DIVB, ST_DIVC: begin
        quo_d = {quo_q[SumW-2:0], ge};
        rem_d = rem_step;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (state_q == ST_DIVA) begin
            state_d = ST_ADJ;
          end else if (state_q == ST_DIVB) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_ADJ: begin
        v_d       = v_sat;
        divisor_d = DivisorW'(qa_eff) * DivisorW'(oq_eff);
        state_d   = ST_LDB;
      end
      ST_LDB: begin
        sign_d  = v_q[SumW-1];
        quo_d   = v_q[SumW-1] ? -v_q : v_q;
        rem_d   = '0;
        cnt_d   = CntW'(SumW - 1);
        state_d = ST_DIVB;
      end
      ST_MUL: begin
        big_d   = (quo_q[SumW-1:EvalW-1] != '0);
        pq_d    = PqW'(quo_q[EvalW-2:0]) * PqW'(cfg_i.scale);
        quo_d   = SumW'(rs);
        rem_d   = '0;
        cnt_d   = CntW'(SumW - 1);
        state_d = ST_DIVC;
      end
      ST_FIN: begin
        if (!res_valid_q || res_pop_i) begin
          res_d       = eval;
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    sign_q    <= sign_d;
    bias_q    <= bias_d;
    white_q   <= white_d;
    v_q       <= v_d;
    big_q     <= big_d;
    pq_q      <= pq_d;
    res_q     <= res_d;
  end

  assign res_valid_o  = res_valid_q;
  assign evaluation_o = res_q;

endmodule

### sv/nnue_squared_crelu_output_eval_core.sv
// ---------------------------------------------------------------------------
// NNUE squared clipped ReLU output layer
// Streams hidden units, accumulates the weighted squares and produces one
// scaled, side-to-move evaluation per vector.
// ---------------------------------------------------------------------------
// Usage. Hidden units are written like a queue: drive the fields and raise
// push; a beat is taken on a rising edge with push high and full low. Up to
// one unit is taken every cycle. Only a unit with last_unit set yields a
// result; the evaluation is read like a queue: while empty is low the oldest
// result sits on evaluation_o and a beat leaves on an edge with pop high.
// Registers are written through the cfg channel (cfg_ready_o is always high)
// and should only be changed while the block holds no unfinished vector.
// A last unit passes the clamp, square and weighting stages into the job
// queue; the output stage then works through three 64-step divisions on
// one shared bit-serial divider plus five control steps before the result
// appears. It takes the next vector only once the current result is stored.
// The job queue holds JOB_DEPTH finished vectors, so units keep streaming
// while the divider works or the receiver stalls; full rises only when every
// job slot is spoken for. A stalled result simply holds on the port.
// Reset clears the running sum, all queues and restores clip 255, quant 64
// and scale 400.
// ---------------------------------------------------------------------------
module nnue_squared_crelu_output_eval_core import nsco_pkg::*; #(
  parameter int JOB_DEPTH = JobDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Hidden unit channel.
  input  logic                    push,
  output logic                    full,
  input  logic signed [DataW-1:0] acc_white_i,
  input  logic signed [DataW-1:0] acc_black_i,
  input  logic signed [DataW-1:0] weight_us_i,
  input  logic signed [DataW-1:0] weight_them_i,
  input  logic signed [DataW-1:0] output_bias_i,
  input  logic                    white_to_move_i,
  input  logic                    last_unit_i,
  // Result channel.
  output logic                    empty,
  input  logic                    pop,
  output logic signed [EvalW-1:0] evaluation_o,
  // Configuration write channel.
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i
);

  localparam int CntW = $clog2(JOB_DEPTH + 1);

  cfg_t            cfg_q;
  job_t            front_job, fifo_job;
  logic            front_push, fifo_valid, back_pop, res_valid;
  logic [CntW-1:0] fifo_free;

  // Configuration registers. Writes to an index beyond the list are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip  <= ClipReset;
      cfg_q.quant <= QuantReset;
      cfg_q.scale <= ScaleReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CLIP:  cfg_q.clip  <= cfg_data_i[ClipW-1:0];
        CFG_QUANT: cfg_q.quant <= cfg_data_i[QuantW-1:0];
        CFG_SCALE: cfg_q.scale <= cfg_data_i[ScaleW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front end runs every cycle it is fed; it stops taking units once the
  // last units already in flight have claimed every free job queue slot.
  nsco_front #(
    .JOB_DEPTH (JOB_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .push            (push),
    .full            (full),
    .acc_white_i     (acc_white_i),
    .acc_black_i     (acc_black_i),
    .weight_us_i     (weight_us_i),
    .weight_them_i   (weight_them_i),
    .output_bias_i   (output_bias_i),
    .white_to_move_i (white_to_move_i),
    .last_unit_i     (last_unit_i),
    .job_free_i      (fifo_free),
    .job_push_o      (front_push),
    .job_o           (front_job)
  );

  nsco_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .job_i   (front_job),
    .pop_i   (back_pop),
    .valid_o (fifo_valid),
    .job_o   (fifo_job),
    .free_o  (fifo_free)
  );

  // The back end takes one job at a time and owns the result register.
  nsco_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .job_valid_i  (fifo_valid),
    .job_i        (fifo_job),
    .job_pop_o    (back_pop),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop),
    .evaluation_o (evaluation_o)
  );

  assign empty = ~res_valid;

endmodule

### sv/nsco_checker.sv
// ---------------------------------------------------------------------------
// NNUE output layer port checker
// Watches the top-level ports and tracks vectors not yet delivered.
// ---------------------------------------------------------------------------
`include "nnue_squared_crelu_output_eval_core_assert.svh"

module nsco_checker import nsco_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    push,
  input logic                    full,
  input logic                    last_unit_i,
  input logic                    empty,
  input logic                    pop,
  input logic signed [EvalW-1:0] evaluation_o
);

  // Last units taken whose result has not yet left.
  logic [7:0] pending_q;
  logic       last_in, res_out;

  assign last_in = push & ~full & last_unit_i;
  assign res_out = pop & ~empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (last_in && !res_out) begin
      pending_q <= pending_q + 1'b1;
    end else if (res_out && !last_in) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  `NSCO_ASSERT_SAME(a_result_needs_last, clk_i, rst_ni, !empty, pending_q != '0, "result shown without a pending vector")
  `NSCO_ASSERT_SAME(a_idle_not_full, clk_i, rst_ni, pending_q == '0, !full, "full raised with no vector in flight")
  `NSCO_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty && !pop, !empty && $stable(evaluation_o), "stalled result changed")

endmodule

bind nnue_squared_crelu_output_eval_core nsco_checker u_nsco_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push         (push),
  .full         (full),
  .last_unit_i  (last_unit_i),
  .empty        (empty),
  .pop          (pop),
  .evaluation_o (evaluation_o)
);
